// ----- rtl/mx86_pkg.sv -----
// Shared types, opcode codes and operand-size helpers for the execute unit.
// No dependencies; used by every file in rtl/.
package mx86_pkg;

    localparam int unsigned WordWidth = 64;
    localparam int unsigned TopBit    = WordWidth - 1;

    localparam logic [WordWidth-1:0] STACK_WORD_BYTES = 64'd8;

    // Instruction kinds
    localparam logic [3:0] KIND_ADD  = 4'd0;
    localparam logic [3:0] KIND_CALL = 4'd1;
    localparam logic [3:0] KIND_CMPQ = 4'd2;
    localparam logic [3:0] KIND_JNE  = 4'd3;
    localparam logic [3:0] KIND_JMP  = 4'd4;
    localparam logic [3:0] KIND_MOVL = 4'd5;
    localparam logic [3:0] KIND_MOVQ = 4'd6;
    localparam logic [3:0] KIND_MOV  = 4'd7;
    localparam logic [3:0] KIND_NOP  = 4'd8;
    localparam logic [3:0] KIND_POP  = 4'd9;
    localparam logic [3:0] KIND_PUSH = 4'd10;
    localparam logic [3:0] KIND_RET  = 4'd11;
    localparam logic [3:0] KIND_SUB  = 4'd12;
    localparam logic [3:0] KIND_XOR  = 4'd13;
    localparam logic [3:0] KIND_DBG  = 4'd14;

    // Operand sizes
    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    // Write-back targets
    localparam logic [1:0] TGT_NONE = 2'd0;
    localparam logic [1:0] TGT_DST  = 2'd1;
    localparam logic [1:0] TGT_SRC  = 2'd2;

    typedef struct packed {
        logic [3:0]           kind;
        logic [1:0]           operand_size;
        logic [WordWidth-1:0] src_value;
        logic [WordWidth-1:0] dst_value;
        logic [WordWidth-1:0] fallthrough_pc;
        logic [WordWidth-1:0] stack_pointer;
        logic [WordWidth-1:0] stack_top_value;
    } item_t;

    typedef struct packed {
        logic [WordWidth-1:0] write_value;
        logic [1:0]           write_target;
        logic [WordWidth-1:0] next_pc;
        logic [WordWidth-1:0] new_stack_pointer;
        logic                 mem_write;
        logic [WordWidth-1:0] mem_data;
        logic                 carry_flag;
        logic                 zero_flag;
        logic                 sign_flag;
        logic                 overflow_flag;
    } result_t;

    typedef struct packed {
        logic carry;
        logic zero;
        logic sign;
        logic overflow;
    } flags_t;

    function automatic logic [WordWidth-1:0] size_mask(input logic [1:0] size);
        logic [WordWidth-1:0] m;
        case (size)
            SIZE_8:  m = 64'h0000_0000_0000_00FF;
            SIZE_16: m = 64'h0000_0000_0000_FFFF;
            SIZE_32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

    function automatic logic msb_at(input logic [WordWidth-1:0] x, input logic [1:0] size);
        logic b;
        case (size)
            SIZE_8:  b = x[7];
            SIZE_16: b = x[15];
            SIZE_32: b = x[31];
            default: b = x[TopBit];
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/mx86_exec.sv -----
// Combinational execute logic: ALU with flags, moves, stack and branch decode.
// Depends on mx86_pkg.
module mx86_exec (
    input  mx86_pkg::item_t   item,
    input  mx86_pkg::flags_t  flags,
    output mx86_pkg::flags_t  flags_next,
    output mx86_pkg::result_t result
);

    logic [mx86_pkg::WordWidth-1:0] mask;
    logic [mx86_pkg::WordWidth-1:0] op_a;
    logic [mx86_pkg::WordWidth-1:0] op_b;
    logic [mx86_pkg::WordWidth-1:0] sum;
    logic [mx86_pkg::WordWidth-1:0] diff;
    logic [mx86_pkg::WordWidth-1:0] xr;
    logic [mx86_pkg::WordWidth-1:0] cmp_diff;
    logic                           a_msb;
    logic                           b_msb;

    assign mask     = mx86_pkg::size_mask(item.operand_size);
    assign op_a     = item.src_value & mask;
    assign op_b     = item.dst_value & mask;
    assign sum      = (op_a + op_b) & mask;
    assign diff     = (op_b - op_a) & mask;
    assign xr       = op_a ^ op_b;
    assign cmp_diff = item.dst_value - item.src_value;
    assign a_msb    = mx86_pkg::msb_at(op_a, item.operand_size);
    assign b_msb    = mx86_pkg::msb_at(op_b, item.operand_size);

    always_comb
    begin
        flags_next = flags;
        result     = '0;
        result.write_target      = mx86_pkg::TGT_NONE;
        result.next_pc           = item.fallthrough_pc;
        result.new_stack_pointer = item.stack_pointer;

        case (item.kind)
            mx86_pkg::KIND_ADD:
            begin
                result.write_value  = (item.dst_value & ~mask) | sum;
                result.write_target = mx86_pkg::TGT_DST;
                flags_next.carry    = sum < op_b;
                flags_next.overflow = (a_msb == b_msb) &&
                                      (b_msb != mx86_pkg::msb_at(sum, item.operand_size));
                flags_next.sign     = mx86_pkg::msb_at(sum, item.operand_size);
                flags_next.zero     = sum == '0;
            end
            mx86_pkg::KIND_SUB:
            begin
                result.write_value  = (item.dst_value & ~mask) | diff;
                result.write_target = mx86_pkg::TGT_DST;
                flags_next.carry    = diff > op_b;
                flags_next.overflow = (a_msb != b_msb) &&
                                      (b_msb != mx86_pkg::msb_at(diff, item.operand_size));
                flags_next.sign     = mx86_pkg::msb_at(diff, item.operand_size);
                flags_next.zero     = diff == '0;
            end
            mx86_pkg::KIND_XOR:
            begin
                result.write_value  = (item.dst_value & ~mask) | xr;
                result.write_target = mx86_pkg::TGT_DST;
                flags_next.carry    = 1'b0;
                flags_next.overflow = 1'b0;
                flags_next.sign     = mx86_pkg::msb_at(xr, item.operand_size);
                flags_next.zero     = xr == '0;
            end
            mx86_pkg::KIND_CMPQ:
            begin
                // full-width compare regardless of operand size
                flags_next.carry    = cmp_diff > item.dst_value;
                flags_next.overflow =
                    (item.dst_value[mx86_pkg::TopBit] ^ item.src_value[mx86_pkg::TopBit]) &
                    (item.dst_value[mx86_pkg::TopBit] ^ cmp_diff[mx86_pkg::TopBit]);
                flags_next.sign     = cmp_diff[mx86_pkg::TopBit];
                flags_next.zero     = cmp_diff == '0;
            end
            mx86_pkg::KIND_MOV,
            mx86_pkg::KIND_MOVQ:
            begin
                result.write_value  = item.src_value;
                result.write_target = mx86_pkg::TGT_DST;
            end
            mx86_pkg::KIND_MOVL:
            begin
                result.write_value  = {item.dst_value[63:32], item.src_value[31:0]};
                result.write_target = mx86_pkg::TGT_DST;
            end
            mx86_pkg::KIND_PUSH:
            begin
                result.new_stack_pointer = item.stack_pointer - mx86_pkg::STACK_WORD_BYTES;
                result.mem_write         = 1'b1;
                result.mem_data          = item.src_value;
            end
            mx86_pkg::KIND_POP:
            begin
                result.write_value       = item.stack_top_value;
                result.write_target      = mx86_pkg::TGT_SRC;
                result.new_stack_pointer = item.stack_pointer + mx86_pkg::STACK_WORD_BYTES;
            end
            mx86_pkg::KIND_CALL:
            begin
                result.new_stack_pointer = item.stack_pointer - mx86_pkg::STACK_WORD_BYTES;
                result.mem_write         = 1'b1;
                result.mem_data          = item.fallthrough_pc;
                result.next_pc           = item.src_value;
            end
            mx86_pkg::KIND_RET:
            begin
                result.next_pc           = item.stack_top_value;
                result.new_stack_pointer = item.stack_pointer + mx86_pkg::STACK_WORD_BYTES;
            end
            mx86_pkg::KIND_JMP:
            begin
                result.next_pc = item.src_value;
            end
            mx86_pkg::KIND_JNE:
            begin
                if (!flags.zero)
                begin
                    result.next_pc = item.src_value;
                end
            end
            default:
            begin
                // nop, dbg and the unused code: no effect
            end
        endcase

        result.carry_flag    = flags_next.carry;
        result.zero_flag     = flags_next.zero;
        result.sign_flag     = flags_next.sign;
        result.overflow_flag = flags_next.overflow;
    end

endmodule

// ----- rtl/mini_x86_execute_unit_core.sv -----
// Execute unit top level: input register, execute logic, result register, flags.
// Depends on mx86_pkg and mx86_exec.
//
// Usage:
//   The item channel (item_valid, item_stall, item) carries one decoded
//   instruction per transaction; the result channel (result_valid,
//   result_stall, result) returns exactly one result per instruction, in
//   order. A transaction completes on a rising edge with valid high and
//   stall low.
//   An accepted instruction passes through the input register and then the
//   result register, where its result is offered until it is taken.
//   Throughput: one instruction per cycle while not stalled; the execute path
//   is one 64-bit add/subtract and compare plus flag selection.
//   The stored flags (CF, ZF, SF, OF) update as an instruction moves from the
//   input register to the result register, so jne sees the flags of the
//   instruction just before it.
//   Reset (rst_n low, asynchronous) clears both valid bits and all flags.
//   When the receiver stalls, the result is held; the input register fills
//   and then item_stall is raised until the result is taken.
module mini_x86_execute_unit_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  mx86_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output mx86_pkg::result_t result
);

    logic              in_valid_reg;
    logic              in_valid_next;
    mx86_pkg::item_t   in_item_reg;
    logic              res_valid_reg;
    logic              res_valid_next;
    mx86_pkg::result_t res_reg;
    mx86_pkg::flags_t  flags_reg;
    mx86_pkg::flags_t  flags_next;
    mx86_pkg::result_t exec_result;
    logic              advance;
    logic              item_take;

    mx86_exec u_exec (
        .item       (in_item_reg),
        .flags      (flags_reg),
        .flags_next (flags_next),
        .result     (exec_result)
    );

    // move the held instruction forward when the result register is free
    assign advance    = in_valid_reg && (!res_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = item_take || (in_valid_reg && !advance);
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_item_reg <= item;
        end
        if (advance)
        begin
            res_reg <= exec_result;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// ----- rtl/mx86_checker.sv -----
// Port-level checks for the execute unit, bound to the top level.
// Depends on mx86_pkg and mini_x86_execute_unit_core.
module mx86_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              item_valid,
    input logic              item_stall,
    input logic              result_valid,
    input logic              result_stall,
    input mx86_pkg::result_t result
);

    // held result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(result))
        else $error("stalled result changed");

    // input backs up only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item stalled with result path free");

    // every transaction is followed by a held stalled result or by a valid result from the result register
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=>
            (result_valid && result_stall) or (##1 result_valid))
        else $error("accepted instruction produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.write_target == mx86_pkg::TGT_NONE)) |->
            ((result.write_value == '0) && (result.mem_write || (result.mem_data == '0))))
        else $error("write value set without a write target");

endmodule

bind mini_x86_execute_unit_core mx86_checker u_mx86_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

// ----- tb/mini_x86_execute_unit_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for mini_x86_execute_unit_core: directed and random instructions,
// predicted outcomes kept in a scoreboard and compared field by field with each result.
// Depends on mx86_pkg and the RTL of the execute unit.
module mini_x86_execute_unit_core_test;

    localparam logic [3:0] KIND_UNUSED = 4'd15;
    localparam int         WatchdogLimit = 1000;
    localparam int         RandomItems = 950;

    class exec_scoreboard;
        mx86_pkg::flags_t  flags;
        mx86_pkg::result_t outcome_q[$];
        int                errors;

        function new();
            flags = '0;
            errors = 0;
        endfunction

        // Execute one instruction against the stored flags.
        function mx86_pkg::result_t exec_outcome(mx86_pkg::item_t it);
            mx86_pkg::result_t r;
            logic [63:0] m, sgn, a, b, c;
            logic a_neg, b_neg, c_neg;
            r = '0;
            r.next_pc = it.fallthrough_pc;
            r.new_stack_pointer = it.stack_pointer;
            m = (it.operand_size == mx86_pkg::SIZE_64) ? '1 :
                ((64'd1 << (8 << it.operand_size)) - 64'd1);
            sgn = (m >> 1) + 64'd1;
            a = it.src_value & m;
            b = it.dst_value & m;
            case (it.kind)
                mx86_pkg::KIND_ADD, mx86_pkg::KIND_SUB, mx86_pkg::KIND_XOR:
                begin
                    if (it.kind == mx86_pkg::KIND_ADD)
                        c = (a + b) & m;
                    else if (it.kind == mx86_pkg::KIND_SUB)
                        c = (b - a) & m;
                    else
                        c = a ^ b;
                    a_neg = (a & sgn) != 0;
                    b_neg = (b & sgn) != 0;
                    c_neg = (c & sgn) != 0;
                    r.write_value = (it.dst_value & ~m) | c;
                    r.write_target = mx86_pkg::TGT_DST;
                    if (it.kind == mx86_pkg::KIND_ADD)
                    begin
                        flags.carry = c < b;
                        flags.overflow = (a_neg == b_neg) && (b_neg != c_neg);
                    end
                    else if (it.kind == mx86_pkg::KIND_SUB)
                    begin
                        flags.carry = c > b;
                        flags.overflow = (a_neg != b_neg) && (b_neg != c_neg);
                    end
                    else
                    begin
                        flags.carry = 1'b0;
                        flags.overflow = 1'b0;
                    end
                    flags.sign = c_neg;
                    flags.zero = c == 0;
                end
                mx86_pkg::KIND_CMPQ:
                begin
                    c = it.dst_value - it.src_value;
                    flags.carry = c > it.dst_value;
                    flags.overflow = (it.dst_value[63] ^ it.src_value[63]) &
                                     (it.dst_value[63] ^ c[63]);
                    flags.sign = c[63];
                    flags.zero = c == 0;
                end
                mx86_pkg::KIND_MOV, mx86_pkg::KIND_MOVQ:
                begin
                    r.write_value = it.src_value;
                    r.write_target = mx86_pkg::TGT_DST;
                end
                mx86_pkg::KIND_MOVL:
                begin
                    r.write_value = {it.dst_value[63:32], it.src_value[31:0]};
                    r.write_target = mx86_pkg::TGT_DST;
                end
                mx86_pkg::KIND_PUSH:
                begin
                    r.new_stack_pointer = it.stack_pointer - mx86_pkg::STACK_WORD_BYTES;
                    r.mem_write = 1'b1;
                    r.mem_data = it.src_value;
                end
                mx86_pkg::KIND_POP:
                begin
                    r.write_value = it.stack_top_value;
                    r.write_target = mx86_pkg::TGT_SRC;
                    r.new_stack_pointer = it.stack_pointer + mx86_pkg::STACK_WORD_BYTES;
                end
                mx86_pkg::KIND_CALL:
                begin
                    r.new_stack_pointer = it.stack_pointer - mx86_pkg::STACK_WORD_BYTES;
                    r.mem_write = 1'b1;
                    r.mem_data = it.fallthrough_pc;
                    r.next_pc = it.src_value;
                end
                mx86_pkg::KIND_RET:
                begin
                    r.next_pc = it.stack_top_value;
                    r.new_stack_pointer = it.stack_pointer + mx86_pkg::STACK_WORD_BYTES;
                end
                mx86_pkg::KIND_JMP:
                    r.next_pc = it.src_value;
                mx86_pkg::KIND_JNE:
                    if (!flags.zero)
                        r.next_pc = it.src_value;
                default:
                    ;
            endcase
            r.carry_flag = flags.carry;
            r.zero_flag = flags.zero;
            r.sign_flag = flags.sign;
            r.overflow_flag = flags.overflow;
            return r;
        endfunction

        function void note_item(mx86_pkg::item_t it);
            outcome_q.push_back(exec_outcome(it));
        endfunction

        function void cmp(string name, logic [63:0] exp_v, logic [63:0] got_v);
            if (exp_v !== got_v)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(mx86_pkg::result_t got);
            mx86_pkg::result_t exp_r;
            if (outcome_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_r = outcome_q.pop_front();
            cmp("write_value", exp_r.write_value, got.write_value);
            cmp("write_target", 64'(exp_r.write_target), 64'(got.write_target));
            cmp("next_pc", exp_r.next_pc, got.next_pc);
            cmp("new_stack_pointer", exp_r.new_stack_pointer, got.new_stack_pointer);
            cmp("mem_write", 64'(exp_r.mem_write), 64'(got.mem_write));
            cmp("mem_data", exp_r.mem_data, got.mem_data);
            cmp("carry_flag", 64'(exp_r.carry_flag), 64'(got.carry_flag));
            cmp("zero_flag", 64'(exp_r.zero_flag), 64'(got.zero_flag));
            cmp("sign_flag", 64'(exp_r.sign_flag), 64'(got.sign_flag));
            cmp("overflow_flag", 64'(exp_r.overflow_flag), 64'(got.overflow_flag));
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    mx86_pkg::item_t   item_in = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    mx86_pkg::result_t result_out;

    exec_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    mini_x86_execute_unit_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_idle_pct);

    // Track both channels and bail out if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_item(item_in);
            if (result_valid && !result_stall)
                sb.check_result(result_out);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("%0t: watchdog expired", $time);
                $display("mini_x86_execute_unit_core regression: fail");
                $finish;
            end
        end
    end

    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000;
            3: return 64'h7FFF_FFFF_FFFF_FFFF;
            4: return 64'd1 << $urandom_range(63);
            5: return (64'd1 << (8 << $urandom_range(3))) - 64'd1;
            6: return 64'(32'($urandom_range(15)));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic mx86_pkg::item_t make_item(logic [3:0] kind, logic [1:0] size,
                                                  logic [63:0] src, logic [63:0] dst);
        mx86_pkg::item_t it;
        it.kind = kind;
        it.operand_size = size;
        it.src_value = src;
        it.dst_value = dst;
        it.fallthrough_pc = {$urandom, $urandom};
        it.stack_pointer = pick_word();
        it.stack_top_value = {$urandom, $urandom};
        return it;
    endfunction

    function automatic mx86_pkg::item_t random_item();
        mx86_pkg::item_t it;
        logic [3:0] kind;
        kind = ($urandom_range(39) == 0) ? KIND_UNUSED : 4'($urandom_range(14));
        it = make_item(kind, 2'($urandom_range(3)), pick_word(), pick_word());
        // Hit zero results more often.
        if ($urandom_range(3) == 0)
            it.src_value = it.dst_value;
        return it;
    endfunction

    // Call at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input mx86_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item_in <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic run_directed();
        mx86_pkg::item_t it;
        send_item(make_item(mx86_pkg::KIND_JNE, mx86_pkg::SIZE_64,
                            64'h0000_1000_0000_0040, '0));
        send_item(make_item(mx86_pkg::KIND_ADD, mx86_pkg::SIZE_8,
                            64'h01, 64'hDEAD_BEEF_0000_00FF));
        send_item(make_item(mx86_pkg::KIND_ADD, mx86_pkg::SIZE_8, 64'h01, 64'h7F));
        send_item(make_item(mx86_pkg::KIND_ADD, mx86_pkg::SIZE_16,
                            64'h8000, 64'hFFFF_FFFF_FFFF_8000));
        send_item(make_item(mx86_pkg::KIND_ADD, mx86_pkg::SIZE_64, '1, '1));
        send_item(make_item(mx86_pkg::KIND_XOR, mx86_pkg::SIZE_8,
                            64'h80, 64'h1234_5678_9ABC_DE01));
        send_item(make_item(mx86_pkg::KIND_SUB, mx86_pkg::SIZE_32,
                            64'h1, 64'hFFFF_FFFF_0000_0000));
        send_item(make_item(mx86_pkg::KIND_SUB, mx86_pkg::SIZE_64,
                            64'h1, 64'h8000_0000_0000_0000));
        send_item(make_item(mx86_pkg::KIND_XOR, mx86_pkg::SIZE_64,
                            64'hA5A5_5A5A_0F0F_F0F0, 64'hA5A5_5A5A_0F0F_F0F0));
        send_item(make_item(mx86_pkg::KIND_CMPQ, mx86_pkg::SIZE_8, '1, '1));
        send_item(make_item(mx86_pkg::KIND_JNE, mx86_pkg::SIZE_64, 64'h4000, '0));
        send_item(make_item(mx86_pkg::KIND_CMPQ, mx86_pkg::SIZE_64, 64'h1, '0));
        send_item(make_item(mx86_pkg::KIND_CMPQ, mx86_pkg::SIZE_64,
                            64'h1, 64'h8000_0000_0000_0000));
        send_item(make_item(mx86_pkg::KIND_JNE, mx86_pkg::SIZE_64,
                            64'hFFFF_FFFF_FFFF_FFF0, '0));
        send_item(make_item(mx86_pkg::KIND_JMP, mx86_pkg::SIZE_64,
                            64'h0000_0000_0040_1000, '0));
        send_item(make_item(mx86_pkg::KIND_MOVL, mx86_pkg::SIZE_64,
                            64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888));
        send_item(make_item(mx86_pkg::KIND_MOVQ, mx86_pkg::SIZE_8, '1, '0));
        send_item(make_item(mx86_pkg::KIND_MOV, mx86_pkg::SIZE_16,
                            64'h8000_0000_0000_0001, '1));
        it = make_item(mx86_pkg::KIND_PUSH, mx86_pkg::SIZE_64, 64'hCAFE_F00D_0000_0001, '0);
        it.stack_pointer = '0;
        send_item(it);
        it = make_item(mx86_pkg::KIND_POP, mx86_pkg::SIZE_64, '0, '0);
        it.stack_pointer = '1;
        send_item(it);
        it = make_item(mx86_pkg::KIND_CALL, mx86_pkg::SIZE_64, 64'h0000_0000_0040_2000, '0);
        it.stack_pointer = 64'h8;
        send_item(it);
        it = make_item(mx86_pkg::KIND_RET, mx86_pkg::SIZE_64, '0, '0);
        it.stack_pointer = 64'hFFFF_FFFF_FFFF_FFF8;
        send_item(it);
        send_item(make_item(mx86_pkg::KIND_NOP, mx86_pkg::SIZE_32, '1, '1));
        send_item(make_item(mx86_pkg::KIND_DBG, mx86_pkg::SIZE_16, '1, '0));
        send_item(make_item(KIND_UNUSED, mx86_pkg::SIZE_8, 64'h55, 64'hAA));
    endtask

    initial
    begin
        sb = new();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 29;
        recv_idle_pct = 45;
        run_directed();
        for (int i = 0; i < RandomItems; i++)
        begin
            if (i == RandomItems / 3)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 29;
            end
            else if (i == 2 * RandomItems / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_item(random_item());
        end
        item_valid <= 1'b0;

        // Drain, then give stray results a chance to show up.
        while (sb.outcome_q.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("mini_x86_execute_unit_core regression: pass");
        else
            $display("mini_x86_execute_unit_core regression: fail");
        $finish;
    end
endmodule
